// File: rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_PRINT = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic REG_ERROR_ATTR   = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_MARK_F  = 8'h46;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

    typedef enum logic [1:0] {
        CMD_PLAIN = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        wr_en;
        logic [6:0]  cell_col;
        logic [4:0]  cell_row;
        logic [15:0] wr_data;
        logic        scroll;
        logic [6:0]  rep_col;
        logic [4:0]  rep_row;
        logic        perr;
    } tcw_cmd_t;

    typedef struct packed {
        logic [6:0] next_column;
        logic [4:0] next_line;
        logic       position_error;
        logic       scrolled;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } tcw_result_t;

endpackage

`default_nettype wire

// File: rtl/core/tcw_front.sv
`default_nettype none

module tcw_front import tcw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_fire,
    input  wire logic [1:0] in_op,
    input  wire logic [7:0] in_char,
    input  wire logic [7:0] in_attr,
    input  wire logic       in_pos,
    input  wire logic [6:0] in_col,
    input  wire logic [4:0] in_line,
    output tcw_cmd_t        cmd
);

    localparam logic [6:0] LAST_COL = 7'(COLS - 1);
    localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

    logic [7:0] def_attr_reg;
    logic [7:0] err_attr_reg;
    logic [6:0] cur_col_reg, cur_col_next;
    logic [4:0] cur_row_reg, cur_row_next;

    logic       in_range;
    logic [6:0] t_col;
    logic [4:0] t_row;
    logic [7:0] use_attr;
    logic [6:0] n_col;
    logic [4:0] n_row;
    logic       row_step;
    logic       wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_attr_reg <= DEFAULT_ATTR_RESET;
            err_attr_reg <= ERROR_ATTR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEFAULT_ATTR: def_attr_reg <= cfg_wdata;
                REG_ERROR_ATTR:   err_attr_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb begin
        in_range = (in_col < 7'(COLS)) && (in_line < 5'(ROWS));
        t_col    = in_pos ? in_col : cur_col_reg;
        t_row    = in_pos ? in_line : cur_row_reg;
        use_attr = (in_attr == 8'd0) ? def_attr_reg : in_attr;

        if (in_char == CHAR_NEWLINE) begin
            n_col    = 7'd0;
            row_step = 1'b1;
        end else if (t_col == LAST_COL) begin
            n_col    = 7'd0;
            row_step = 1'b1;
        end else begin
            n_col    = t_col + 7'd1;
            row_step = 1'b0;
        end
        wrap = row_step && (t_row == LAST_ROW);
        if (wrap) begin
            n_row = LAST_ROW;
        end else if (row_step) begin
            n_row = t_row + 5'd1;
        end else begin
            n_row = t_row;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.kind     = CMD_PLAIN;
        cmd.rep_col  = cur_col_reg;
        cmd.rep_row  = cur_row_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        unique case (in_op)
            OP_PRINT: begin
                if (in_pos && !in_range) begin
                    cmd.wr_en    = 1'b1;
                    cmd.cell_col = LAST_COL;
                    cmd.cell_row = LAST_ROW;
                    cmd.wr_data  = {err_attr_reg, CHAR_MARK_F};
                    cmd.perr     = 1'b1;
                    cmd.rep_col  = in_col;
                    cmd.rep_row  = in_line;
                end else begin
                    cmd.wr_en    = (in_char != CHAR_NEWLINE);
                    cmd.cell_col = t_col;
                    cmd.cell_row = t_row;
                    cmd.wr_data  = {use_attr, in_char};
                    cmd.scroll   = wrap;
                    cmd.rep_col  = n_col;
                    cmd.rep_row  = n_row;
                    cur_col_next = n_col;
                    cur_row_next = n_row;
                end
            end
            OP_CLEAR: begin
                cmd.kind     = CMD_CLEAR;
                cmd.wr_data  = {def_attr_reg, CHAR_SPACE};
                cmd.rep_col  = 7'd0;
                cmd.rep_row  = 5'd0;
                cur_col_next = 7'd0;
                cur_row_next = 5'd0;
            end
            OP_READ: begin
                if (in_range) begin
                    cmd.kind     = CMD_READ;
                    cmd.cell_col = in_col;
                    cmd.cell_row = in_line;
                end else begin
                    cmd.perr    = 1'b1;
                    cmd.rep_col = in_col;
                    cmd.rep_row = in_line;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= 7'd0;
            cur_row_reg <= 5'd0;
        end else if (in_fire) begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_cmd_fifo.sv
`default_nettype none

module tcw_cmd_fifo import tcw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire tcw_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output tcw_cmd_t      head_cmd
);

    tcw_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_back.sv
`default_nettype none

module tcw_back import tcw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     head_valid,
    input  wire tcw_cmd_t head_cmd,
    output logic       pop,
    output logic       init_done,
    output logic       out_valid,
    input  wire logic  out_ready,
    output tcw_result_t out_result
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] COLS_A     = AW'(COLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLS);
    localparam logic [AW-1:0] ONE_A      = AW'(1);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCROLL = 6'b000100,
        ST_BLANK  = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_OUT    = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    tcw_cmd_t      cur_reg;
    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_data_reg;
    logic          out_valid_reg;
    tcw_result_t   out_result_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] head_addr;
    logic          out_load;

    assign head_addr = AW'(AW'(head_cmd.cell_row) * COLS_A) + AW'(head_cmd.cell_col);
    assign init_done = (state_reg != ST_INIT);
    assign out_valid = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg;
        mem_wdata  = 16'd0;
        mem_re     = 1'b0;
        mem_raddr  = cnt_reg + COLS_A;
        unique case (state_reg)
            ST_INIT: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + ONE_A;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (head_valid) begin
                    pop       = 1'b1;
                    mem_we    = head_cmd.wr_en;
                    mem_waddr = head_addr;
                    mem_wdata = head_cmd.wr_data;
                    mem_re    = (head_cmd.kind == CMD_READ);
                    mem_raddr = head_addr;
                    cnt_next  = '0;
                    if (head_cmd.kind == CMD_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (head_cmd.scroll) begin
                        state_next = ST_SCROLL;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCROLL: begin
                mem_re    = (cnt_reg != SCROLL_END);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - ONE_A;
                mem_wdata = rd_data_reg;
                if (cnt_reg == SCROLL_END) begin
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = cnt_reg + ONE_A;
                end
            end
            ST_BLANK: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + ONE_A;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_OUT;
                end
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = cur_reg.wr_data;
                cnt_next  = cnt_reg + ONE_A;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_cmd;
        end
        if (out_load) begin
            out_result_reg.next_column    <= cur_reg.rep_col;
            out_result_reg.next_line      <= cur_reg.rep_row;
            out_result_reg.position_error <= cur_reg.perr;
            out_result_reg.scrolled       <= cur_reg.scroll;
            if (cur_reg.kind == CMD_READ) begin
                out_result_reg.read_char <= rd_data_reg[7:0];
                out_result_reg.read_attr <= rd_data_reg[15:8];
            end else begin
                out_result_reg.read_char <= 8'd0;
                out_result_reg.read_attr <= 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// A print, read or no-op transaction enters the command FIFO on acceptance; the back end
// pops it when idle and raises m_tvalid from its output state. Commands are accepted
// until the two-entry FIFO fills; scrolling prints and clears add memory-sweep states.
// Reset (aresetn low, synchronous) homes the cursor, loads default attributes, then
// sweeps the cell memory to zero with s_tready low.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] char_code, [15:8] attribute, [16] positioned, [23:17] column, [28:24] line
    input  wire logic [31:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] next_column, [11:7] next_line, [12] position_error, [13] scrolled,
    // [21:14] read_char, [29:22] read_attr
    output logic [31:0]      m_tdata
);

    tcw_cmd_t    front_cmd;
    tcw_cmd_t    head_cmd;
    tcw_result_t result;
    logic        fifo_full;
    logic        head_valid;
    logic        pop;
    logic        init_done;
    logic        in_fire;

    assign s_tready = init_done && !fifo_full;
    assign in_fire  = s_tvalid && s_tready;

    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_op     (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_attr   (s_tdata[15:8]),
        .in_pos    (s_tdata[16]),
        .in_col    (s_tdata[23:17]),
        .in_line   (s_tdata[28:24]),
        .cmd       (front_cmd)
    );

    tcw_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_fire),
        .push_cmd   (front_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .init_done  (init_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {2'b00, result.read_attr, result.read_char, result.scrolled,
                      result.position_error, result.next_line, result.next_column};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import tcw_pkg::*;;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;

    class console_mirror;
        logic [15:0] cells [CELLS];
        int cursor;
        logic [7:0] dflt_attr;
        logic [7:0] err_attr;
        tcw_result_t pending_reports[$];
        int errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor = 0;
            dflt_attr = DEFAULT_ATTR_RESET;
            err_attr = ERROR_ATTR_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == REG_DEFAULT_ATTR) dflt_attr = value;
            else err_attr = value;
        endfunction

        function void apply_command(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                    logic positioned, logic [6:0] col, logic [4:0] row);
            tcw_result_t r;
            int off;
            logic [7:0] a;
            bit in_range;
            r = '0;
            in_range = (int'(col) < COLS) && (int'(row) < ROWS);
            r.next_column = 7'(cursor % COLS);
            r.next_line = 5'(cursor / COLS);
            case (op)
                OP_PRINT: begin
                    a = (attr == 8'd0) ? dflt_attr : attr;
                    if (positioned && !in_range) begin
                        cells[CELLS-1] = {err_attr, CHAR_MARK_F};
                        r.position_error = 1'b1;
                        r.next_column = col;
                        r.next_line = row;
                    end else begin
                        off = positioned ? int'(row) * COLS + int'(col) : cursor;
                        if (ch == CHAR_NEWLINE) begin
                            off = (off / COLS + 1) * COLS;
                        end else begin
                            cells[off] = {a, ch};
                            off++;
                        end
                        if (off >= CELLS) begin
                            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                            for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = '0;
                            off -= COLS;
                            r.scrolled = 1'b1;
                        end
                        cursor = off;
                        r.next_column = 7'(off % COLS);
                        r.next_line = 5'(off / COLS);
                    end
                end
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = {dflt_attr, CHAR_SPACE};
                    cursor = 0;
                    r.next_column = '0;
                    r.next_line = '0;
                end
                OP_READ: begin
                    if (in_range) begin
                        r.read_char = cells[int'(row) * COLS + int'(col)][7:0];
                        r.read_attr = cells[int'(row) * COLS + int'(col)][15:8];
                    end else begin
                        r.position_error = 1'b1;
                        r.next_column = col;
                        r.next_line = row;
                    end
                end
                default: ;
            endcase
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch: expected %0d actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_report(logic [31:0] d);
            tcw_result_t e;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none actual %h",
                         $time, d);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            compare_field("next_column", e.next_column, d[6:0]);
            compare_field("next_line", e.next_line, d[11:7]);
            compare_field("position_error", e.position_error, d[12]);
            compare_field("scrolled", e.scrolled, d[13]);
            compare_field("read_char", e.read_char, d[21:14]);
            compare_field("read_attr", e.read_attr, d[29:22]);
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    console_mirror mirror;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    text_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.check_report(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_command(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                logic positioned, logic [6:0] col, logic [4:0] row);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, row, col, positioned, attr, ch};
        do @(posedge aclk); while (!s_tready);
        mirror.apply_command(op, ch, attr, positioned, col, row);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (mirror.pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic idx, logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mirror.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic random_command();
        int pick;
        int c;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
        pick = $urandom_range(999);
        ch = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) ch = CHAR_NEWLINE;
        attr = 8'($urandom_range(255));
        if ($urandom_range(7) == 0) attr = 8'd0;
        col = 7'($urandom_range(COLS - 1));
        row = 5'($urandom_range(ROWS - 1));
        if ($urandom_range(3) == 0) row = 5'(ROWS - 1);
        if (pick < 450) begin
            send_command(OP_PRINT, ch, attr, 1'b0, 7'($urandom_range(127)),
                         5'($urandom_range(31)));
        end else if (pick < 650) begin
            send_command(OP_PRINT, ch, attr, 1'b1, col, row);
        end else if (pick < 700) begin
            col = 7'($urandom_range(127));
            row = 5'($urandom_range(31));
            if (int'(col) < COLS && int'(row) < ROWS) col = 7'(COLS + $urandom_range(127 - COLS));
            send_command(OP_PRINT, ch, attr, 1'b1, col, row);
        end else if (pick < 940) begin
            c = mirror.cursor;
            if ($urandom_range(1) == 0 && c > 0) begin
                col = 7'((c - 1) % COLS);
                row = 5'((c - 1) / COLS);
            end else if ($urandom_range(9) == 0) begin
                col = 7'($urandom_range(127));
                row = 5'($urandom_range(31));
            end
            send_command(OP_READ, ch, attr, 1'($urandom_range(1)), col, row);
        end else if (pick < 970) begin
            send_command(OP_NOP, ch, attr, 1'($urandom_range(1)), 7'($urandom_range(127)),
                         5'($urandom_range(31)));
        end else if (pick < 985) begin
            send_command(OP_CLEAR, ch, attr, 1'($urandom_range(1)), col, row);
        end else begin
            send_command(OP_PRINT, ch, attr, 1'b1, 7'(COLS - 1), 5'(ROWS - 1));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count, bit hold_off);
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        if (hold_off) hold_left = HOLD_OFF_CYCLES;
        repeat (count) random_command();
        drain();
    endtask

    initial begin
        mirror = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_command(OP_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'(COLS - 1), 5'(ROWS - 1));
        send_command(OP_PRINT, "A", 8'h00, 1'b0, 7'd0, 5'd0);
        send_command(OP_PRINT, 8'hFF, 8'hFF, 1'b1, 7'(COLS - 1), 5'd0);
        send_command(OP_PRINT, CHAR_NEWLINE, 8'h12, 1'b0, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'(COLS - 1), 5'd0);
        send_command(OP_PRINT, CHAR_NEWLINE, 8'h34, 1'b1, 7'd10, 5'(ROWS - 1));
        send_command(OP_PRINT, "Z", 8'h56, 1'b1, 7'(COLS - 1), 5'(ROWS - 1));
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'(COLS - 1), 5'(ROWS - 2));
        send_command(OP_PRINT, "q", 8'h01, 1'b1, 7'(COLS), 5'd0);
        send_command(OP_PRINT, "r", 8'h00, 1'b1, 7'd127, 5'd31);
        send_command(OP_PRINT, "s", 8'h02, 1'b1, 7'd0, 5'(ROWS));
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'(COLS - 1), 5'(ROWS - 1));
        send_command(OP_READ, 8'hFF, 8'hFF, 1'b1, 7'(COLS), 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31);
        send_command(OP_NOP, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
        send_command(OP_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'd5, 5'd5);
        send_command(OP_PRINT, 8'h00, 8'h01, 1'b0, 7'd0, 5'd0);
        send_command(OP_PRINT, 8'h7F, 8'h80, 1'b1, 7'd1, 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0);
        send_command(OP_READ, 8'h00, 8'h00, 1'b1, 7'd1, 5'd0);
        drain();

        cfg_write(REG_DEFAULT_ATTR, 8'h00);
        cfg_write(REG_ERROR_ATTR, 8'hFF);
        run_phase(0, 0, 232, 1'b1);

        cfg_write(REG_DEFAULT_ATTR, 8'hFF);
        cfg_write(REG_ERROR_ATTR, 8'h00);
        run_phase(47, 0, 232, 1'b0);

        cfg_write(REG_DEFAULT_ATTR, 8'($urandom_range(255)));
        cfg_write(REG_ERROR_ATTR, 8'($urandom_range(255)));
        run_phase(0, 47, 232, 1'b0);

        cfg_write(REG_DEFAULT_ATTR, 8'($urandom_range(255)));
        cfg_write(REG_ERROR_ATTR, 8'($urandom_range(255)));
        run_phase(31, 31, 232, 1'b0);

        if (mirror.errors == 0 && mirror.pending_reports.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
